FILE: hw/rtl/qbz_pkg.sv
// shared widths, constants and types of the quadratic bezier sampler
package qbz_pkg;

    localparam int COORD_W   = 16;
    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = $clog2(MAX_STEPS + 1);
    localparam int DEN_W     = $clog2(MAX_STEPS * MAX_STEPS + 1);
    localparam int NUM_W     = COORD_W + DEN_W;
    localparam int ACC_W     = NUM_W + 1;
    localparam int MUL_A_W   = COORD_W + 1;
    localparam int MUL_B_W   = DEN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DCNT_W    = $clog2(COORD_W + 1);

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(16);

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } mac_ctrl_t;

    // zero step count acts as one, oversized counts saturate
    function automatic logic [STEP_W-1:0] clamp_steps(input logic [STEP_W-1:0] raw);
        logic [STEP_W-1:0] res;
        res = raw;
        if (raw == '0)
        begin
            res = STEP_W'(1);
        end
        else if (raw > STEP_W'(MAX_STEPS))
        begin
            res = STEP_W'(MAX_STEPS);
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/qbz_mac.sv
// shared multiplier with registered product and accumulator
module qbz_mac
    import qbz_pkg::*;
(
    input  logic                      clk,
    input  mac_ctrl_t                 ctrl,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic signed [MUL_B_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]   acc_init,
    output logic signed [PROD_W-1:0]  prod,
    output logic signed [ACC_W-1:0]   acc
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= acc_init;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

FILE: hw/rtl/qbz_div.sv
// restoring divider, one quotient bit per cycle; quotient known to fit COORD_W bits
module qbz_div
    import qbz_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic               busy,
    output logic [COORD_W-1:0] quo
);

    logic [DCNT_W-1:0]  cnt_reg;
    logic [DCNT_W-1:0]  cnt_next;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [COORD_W-1:0] quo_reg;
    logic [COORD_W-1:0] quo_next;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     trial;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[COORD_W-1]};
        trial    = shifted - {1'b0, den};
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            // high part is below den since the quotient fits COORD_W bits
            rem_next = num[NUM_W-1:COORD_W];
            quo_next = num[COORD_W-1:0];
            cnt_next = DCNT_W'(COORD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - DCNT_W'(1);
            if (shifted >= {1'b0, den})
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[COORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[COORD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

FILE: hw/rtl/quadratic_bezier_sampler.sv
// items are taken only while idle, so a new item waits until the last point of the current one is registered
// per point: weights on the shared multiplier, then per axis a multiply-accumulate pass and a
// 16-step divider pass
// reset: async active low, step count returns to 16, sequencer idle, no output pending
module quadratic_bezier_sampler
    import qbz_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [STEP_W-1:0]      cfg_wdata,      // step_count
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [6*COORD_W-1:0]   s_axis_tdata,   // start_x, start_y, mid_x, mid_y, end_x, end_y
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [2*COORD_W-1:0]   m_axis_tdata,   // curve_x, curve_y
    output logic                   m_axis_tlast
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WGT  = 3'd1;
    localparam logic [2:0] ST_MAC  = 3'd2;
    localparam logic [2:0] ST_DIVS = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             phase_reg, phase_next;
    logic                   axis_reg, axis_next;
    logic [STEP_W-1:0]      pt_idx_reg, pt_idx_next;
    logic [STEP_W-1:0]      step_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [6*COORD_W-1:0]   in_reg, in_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [DEN_W-1:0]       w0_reg, w0_next;
    logic [DEN_W-1:0]       w1_reg, w1_next;
    logic [DEN_W-1:0]       w2_reg, w2_next;
    logic [COORD_W-1:0]     x_reg, x_next;
    logic [2*COORD_W-1:0]   out_data_reg, out_data_next;
    logic                   out_last_reg, out_last_next;

    logic [STEP_W-1:0]      n_eff;
    logic [STEP_W-1:0]      j_val;
    mac_ctrl_t              mac_ctrl;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   acc_init;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;
    logic                   div_start;
    logic                   div_busy;
    logic [COORD_W-1:0]     quo;
    logic [COORD_W-1:0]     quo_coord;
    logic [COORD_W-1:0]     term_coord;

    assign n_eff = clamp_steps(step_reg);
    assign j_val = n_eff - pt_idx_reg;
    // numerator carried an offset of den << (COORD_W-1): undo by flipping the top bit
    assign quo_coord = {~quo[COORD_W-1], quo[COORD_W-2:0]};
    assign acc_init  = ACC_W'({den_reg, {(COORD_W-1){1'b0}}});

    always_comb
    begin
        case (phase_reg)
            3'd0:    term_coord = axis_reg ? in_reg[1*COORD_W +: COORD_W]
                                           : in_reg[0*COORD_W +: COORD_W];
            3'd1:    term_coord = axis_reg ? in_reg[3*COORD_W +: COORD_W]
                                           : in_reg[2*COORD_W +: COORD_W];
            default: term_coord = axis_reg ? in_reg[5*COORD_W +: COORD_W]
                                           : in_reg[4*COORD_W +: COORD_W];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        axis_next      = axis_reg;
        pt_idx_next    = pt_idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        in_next        = in_reg;
        den_next       = den_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        x_next         = x_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        mac_ctrl       = '0;
        op_a           = '0;
        op_b           = '0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next     = s_axis_tdata;
                    pt_idx_next = STEP_W'(1);
                    phase_next  = '0;
                    state_next  = ST_WGT;
                end
            end
            ST_WGT:
            begin
                // weights j*j, 2*j*i, i*i and den n*n through the shared multiplier
                mac_ctrl.mul_en = 1'b1;
                phase_next      = phase_reg + 3'd1;
                case (phase_reg)
                    3'd0:
                    begin
                        op_a = MUL_A_W'(n_eff);
                        op_b = MUL_B_W'(n_eff);
                    end
                    3'd1:
                    begin
                        op_a     = MUL_A_W'(j_val);
                        op_b     = MUL_B_W'(j_val);
                        den_next = prod[DEN_W-1:0];
                    end
                    3'd2:
                    begin
                        op_a    = MUL_A_W'(j_val);
                        op_b    = MUL_B_W'(pt_idx_reg);
                        w0_next = prod[DEN_W-1:0];
                    end
                    3'd3:
                    begin
                        op_a    = MUL_A_W'(pt_idx_reg);
                        op_b    = MUL_B_W'(pt_idx_reg);
                        w1_next = {prod[DEN_W-2:0], 1'b0};
                    end
                    default:
                    begin
                        w2_next    = prod[DEN_W-1:0];
                        phase_next = '0;
                        axis_next  = 1'b0;
                        state_next = ST_MAC;
                    end
                endcase
            end
            ST_MAC:
            begin
                mac_ctrl.mul_en = 1'b1;
                op_a            = {term_coord[COORD_W-1], term_coord};
                phase_next      = phase_reg + 3'd1;
                case (phase_reg)
                    3'd0:
                    begin
                        mac_ctrl.acc_load = 1'b1;
                        op_b              = {1'b0, w0_reg};
                    end
                    3'd1:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        op_b             = {1'b0, w1_reg};
                    end
                    3'd2:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        op_b             = {1'b0, w2_reg};
                    end
                    default:
                    begin
                        mac_ctrl.acc_add = 1'b1;
                        mac_ctrl.mul_en  = 1'b0;
                        phase_next       = '0;
                        state_next       = ST_DIVS;
                    end
                endcase
            end
            ST_DIVS:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    if (!axis_reg)
                    begin
                        x_next     = quo_coord;
                        axis_next  = 1'b1;
                        state_next = ST_MAC;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {quo_coord, x_reg};
                    out_last_next  = (pt_idx_reg == n_eff);
                    phase_next     = '0;
                    if (pt_idx_reg == n_eff)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pt_idx_next = pt_idx_reg + STEP_W'(1);
                        state_next  = ST_WGT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            axis_reg      <= 1'b0;
            pt_idx_reg    <= STEP_W'(1);
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            axis_reg      <= axis_next;
            pt_idx_reg    <= pt_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        den_reg      <= den_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        x_reg        <= x_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    qbz_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .op_a     (op_a),
        .op_b     (op_b),
        .acc_init (acc_init),
        .prod     (prod),
        .acc      (acc)
    );

    qbz_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc[NUM_W-1:0]),
        .den   (den_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (pt_idx_reg != '0) && (pt_idx_reg <= n_eff))
        else $error("point index out of range");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider busy outside divide state");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("output raised outside output state");
`endif

endmodule

FILE: tb/tb_quadratic_bezier_sampler.sv
// self-checking testbench of the quadratic bezier sampler with exact curve point prediction
`timescale 1ns / 1ps

module tb_quadratic_bezier_sampler;
    import qbz_pkg::*;

    localparam int RANDOM_ITEMS   = 218;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CROSS_WEIGHT   = 2;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } curve_point_t;

    // predicts the sampled points of each control-point triple and checks them in order
    class curve_predictor;
        logic [STEP_W-1:0] step_reg;
        curve_point_t      expected_points[$];
        int unsigned       errors;

        function new();
            step_reg = STEP_RESET;
            errors   = 0;
        endfunction

        function void set_steps(logic [STEP_W-1:0] value);
            step_reg = value;
        endfunction

        function int pending();
            return expected_points.size();
        endfunction

        // exact weighted sum over n squared, rounded toward minus infinity
        function logic [COORD_W-1:0] axis_point(longint a, longint b, longint c,
                                                longint i, longint n);
            longint j;
            longint num;
            longint den;
            longint q;
            j   = n - i;
            num = j * j * a + CROSS_WEIGHT * j * i * b + i * i * c;
            den = n * n;
            q   = num / den;
            if (num % den != 0 && num < 0)
            begin
                q = q - 1;
            end
            return q[COORD_W-1:0];
        endfunction

        function void note_triple(logic [6*COORD_W-1:0] d);
            longint       sx;
            longint       sy;
            longint       mx;
            longint       my;
            longint       ex;
            longint       ey;
            longint       n;
            curve_point_t p;
            sx = $signed(d[0*COORD_W +: COORD_W]);
            sy = $signed(d[1*COORD_W +: COORD_W]);
            mx = $signed(d[2*COORD_W +: COORD_W]);
            my = $signed(d[3*COORD_W +: COORD_W]);
            ex = $signed(d[4*COORD_W +: COORD_W]);
            ey = $signed(d[5*COORD_W +: COORD_W]);
            n  = step_reg;
            if (n < 1)
            begin
                n = 1;
            end
            if (n > MAX_STEPS)
            begin
                n = MAX_STEPS;
            end
            for (longint i = 1; i <= n; i++)
            begin
                p.x    = axis_point(sx, mx, ex, i, n);
                p.y    = axis_point(sy, my, ey, i, n);
                p.last = (i == n);
                expected_points.insert(expected_points.size(), p);
            end
        endfunction

        function void check_point(logic [2*COORD_W-1:0] d, logic last);
            curve_point_t want;
            logic [COORD_W-1:0] got_x;
            logic [COORD_W-1:0] got_y;
            got_x = d[0 +: COORD_W];
            got_y = d[COORD_W +: COORD_W];
            if (expected_points.size() == 0)
            begin
                $error("unexpected curve point x=%0d y=%0d last=%0b",
                       $signed(got_x), $signed(got_y), last);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            if (got_x !== want.x)
            begin
                $error("curve_x: expected %0d, got %0d", $signed(want.x), $signed(got_x));
                errors++;
            end
            if (got_y !== want.y)
            begin
                $error("curve_y: expected %0d, got %0d", $signed(want.y), $signed(got_y));
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_point: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [STEP_W-1:0]    cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [6*COORD_W-1:0] s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [2*COORD_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    curve_predictor predictor;
    logic           quiet;

    quadratic_bezier_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // mostly short gaps, now and then a long one; none in quiet phases
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            3: return COORD_W'($urandom_range(0, 16)) - COORD_W'(8);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [6*COORD_W-1:0] pack_triple(
        logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
        logic [COORD_W-1:0] mx, logic [COORD_W-1:0] my,
        logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
        return {ey, ex, my, mx, sy, sx};
    endfunction

    // step counts of the phases: extremes and out-of-range values first, then mostly small
    function automatic logic [STEP_W-1:0] pick_steps(int phase);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (phase)
            0: return STEP_W'(1);
            1: return STEP_W'(MAX_STEPS);
            2: return '0;
            3: return '1;
            4: return STEP_W'(MAX_STEPS + 1);
            5: return STEP_W'(2);
            default:
            begin
                if (r < 80)
                begin
                    return STEP_W'($urandom_range(1, 12));
                end
                if (r < 90)
                begin
                    return STEP_W'($urandom_range(13, 40));
                end
                return STEP_W'($urandom_range(0, 127));
            end
        endcase
    endfunction

    task automatic send_triple(input logic [6*COORD_W-1:0] d);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predictor.note_triple(d);
    endtask

    task automatic wait_drained();
        while (predictor.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_steps(input logic [STEP_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        predictor.set_steps(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin : point_sink
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                predictor.check_point(m_axis_tdata, m_axis_tlast);
            end
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        logic [COORD_W-1:0]  cmin;
        logic [COORD_W-1:0]  cmax;
        logic [STEP_W-1:0]   step_val;
        int                  phase;
        int                  phase_items;
        int                  random_sent;
        cmin          = {1'b1, {(COORD_W-1){1'b0}}};
        cmax          = {1'b0, {(COORD_W-1){1'b1}}};
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        quiet         = 1'b0;
        predictor     = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at the reset step count
        send_triple(pack_triple('0, '0, '0, '0, '0, '0));
        send_triple(pack_triple(cmax, cmax, cmax, cmax, cmax, cmax));
        send_triple(pack_triple(cmin, cmin, cmin, cmin, cmin, cmin));
        send_triple(pack_triple(cmin, cmax, cmax, cmin, cmin, cmax));
        send_triple(pack_triple(cmax, cmin, cmin, cmax, cmax, cmin));
        send_triple(pack_triple('0, '0, cmax, cmin, '0, '0));
        // small negative values exercise rounding toward minus infinity
        send_triple(pack_triple('1, '1, '0, '0, '0, '0));
        send_triple(pack_triple('0, '0, '1, '1, '0, '0));
        send_triple(pack_triple(16'd1, 16'hFFFF, 16'hFFFD, 16'd3, 16'd2, 16'hFFFE));
        send_triple(pack_triple(16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00));
        send_triple(pack_triple(16'hAAAA, 16'h5555, 16'hF0F0, 16'h0F0F, 16'hFF00, 16'h00FF));
        send_triple(pack_triple(cmin, '0, '1, cmax, 16'd1, cmin));
        s_axis_tvalid <= 1'b0;
        wait_drained();

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            step_val = pick_steps(phase);
            write_steps(step_val);
            quiet = ($urandom_range(0, 3) == 0);
            // long runs are slow, so few items at large step counts
            phase_items = (step_val > 32) ? 3 : 20;
            if (phase_items > RANDOM_ITEMS - random_sent)
            begin
                phase_items = RANDOM_ITEMS - random_sent;
            end
            repeat (phase_items)
            begin
                send_triple(pack_triple(rand_coord(), rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord(), rand_coord()));
                random_sent++;
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predictor.errors == 0 && predictor.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
